/* rtl/pfsc_pkg.sv */
`default_nettype none
package pfsc_pkg;

    localparam int CFG_W        = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int OP_W         = 2;
    localparam int ELEV_FIELD_W = 20;
    localparam int CNT_FIELD_W  = 13;
    localparam int YEAR_W       = 20;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 40;

    localparam logic [YEAR_W-1:0] LEVEL_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        HS_IDLE,
        HS_UP_RD,
        HS_UP_CMP,
        HS_DN_LAST,
        HS_DN_KEY,
        HS_DN_RD,
        HS_DN_CMP
    } heap_state_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEED_NEXT,
        ST_CHECK,
        ST_DIV,
        ST_NB,
        ST_MARK_RD,
        ST_MARK_CHK
    } ctrl_state_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } heap_cmd_t;

endpackage
`default_nettype wire

/* rtl/priority_flood_sinking_count_top.sv */
// load: one elevation stored per beat; restart: clears all MAX_ROWS*MAX_COLS visited marks;
// neither has a result. advance, first call: seeds each border cell (mark read and check,
// push if unvisited, waiting while the push climbs the heap). each sunk cell: a pop check
// and row/column divide, then a mark read and check per neighbor, pushing unvisited ones,
// waiting while a heap push or pop runs; one result. one item in flight, the result beat
// sits in an output register; async active-low reset, then all marks clear, s_tready low
`default_nettype none
module priority_flood_sinking_count_top import pfsc_pkg::*; #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 64,
    parameter int ELEV_BITS = 20
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // elevation
    input  logic [OP_W-1:0]       s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // cells_remaining, year_reported
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int KEY_W = ELEV_BITS + IDX_W;

    logic [ELEV_BITS-1:0] elev_mem [CELLS];
    logic                 vis_mem  [CELLS];

    ctrl_state_t          state_reg, state_next;
    logic [CFG_W-1:0]     row_count_reg, col_count_reg;
    logic [CNT_W-1:0]     lp_reg, lp_next;
    logic [YEAR_W-1:0]    sea_reg, sea_next;
    logic [CNT_W-1:0]     above_reg, above_next;
    logic                 seeded_reg, seeded_next;
    logic [IDX_W-1:0]     clr_reg, clr_next;
    logic [CFG_W-1:0]     sr_reg, sr_next, sc_reg, sc_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [IDX_W-1:0]     pop_idx_reg, pop_idx_next;
    logic [IDX_W-1:0]     r_reg, r_next;
    logic [CFG_W-1:0]     c_reg, c_next;
    dir_t                 dir_reg, dir_next;
    logic                 nb_last_reg, nb_last_next;
    logic [IDX_W-1:0]     nidx_reg, nidx_next;
    logic                 seeding_reg, seeding_next;
    logic                 out_pend_reg, out_pend_next;
    logic                 out_valid_reg;
    logic [CNT_FIELD_W-1:0] out_cnt_reg;
    logic [YEAR_W-1:0]    out_year_reg;

    logic [ELEV_BITS-1:0] elev_rd_reg;
    logic                 vis_rd_reg;

    logic [CFG_W-1:0]     rows, cols;
    logic [2*CFG_W-1:0]   area_full;
    logic [CNT_W-1:0]     area;
    logic                 in_beat, load_ok, out_free;
    op_t                  op;
    logic [ELEV_BITS-1:0] in_elev;

    heap_cmd_t            hcmd;
    logic [KEY_W-1:0]     hpush_key, htop;
    logic                 hbusy;
    logic [CNT_W-1:0]     hsize;
    logic [ELEV_BITS-1:0] top_elev;
    logic                 sink;

    logic                 div_start, div_done;
    logic [IDX_W-1:0]     div_q;
    logic [CFG_W-1:0]     div_r;

    logic                 nb_ok;
    logic [IDX_W-1:0]     nb_idx;
    logic                 interior, c_last, r_last;

    logic                 elev_we, vis_we, vis_wdata;
    logic [IDX_W-1:0]     vis_waddr;

    always_comb
    begin
        if (row_count_reg == '0)
            rows = CFG_W'(1);
        else if (32'(row_count_reg) > MAX_ROWS)
            rows = CFG_W'(MAX_ROWS);
        else
            rows = row_count_reg;
        if (col_count_reg == '0)
            cols = CFG_W'(1);
        else if (32'(col_count_reg) > MAX_COLS)
            cols = CFG_W'(MAX_COLS);
        else
            cols = col_count_reg;
        area_full = (2*CFG_W)'(rows) * (2*CFG_W)'(cols);
        area      = CNT_W'(area_full);
    end

    assign op       = op_t'(s_tuser);
    assign in_elev  = ELEV_BITS'(s_tdata[ELEV_FIELD_W-1:0]);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign load_ok  = !seeded_reg && (32'(lp_reg) < 32'(area)) && (32'(lp_reg) < CELLS);
    assign out_free = !out_valid_reg || m_tready;
    assign top_elev = htop[KEY_W-1 -: ELEV_BITS];
    assign sink     = (hsize != '0) && (33'(top_elev) <= 33'(sea_reg));

    assign interior = (sr_reg != '0) && (sr_reg != rows - CFG_W'(1));
    assign c_last   = (8'(sc_reg) + 8'd1) >= 8'(cols);
    assign r_last   = (8'(sr_reg) + 8'd1) >= 8'(rows);

    always_comb
    begin
        unique case (dir_reg)
            DIR_DOWN:
            begin
                nb_ok  = (33'(r_reg) + 33'd1) < 33'(rows);
                nb_idx = pop_idx_reg + IDX_W'(cols);
            end
            DIR_RIGHT:
            begin
                nb_ok  = (8'(c_reg) + 8'd1) < 8'(cols);
                nb_idx = pop_idx_reg + IDX_W'(1);
            end
            DIR_UP:
            begin
                nb_ok  = (r_reg != '0);
                nb_idx = pop_idx_reg - IDX_W'(cols);
            end
            DIR_LEFT:
            begin
                nb_ok  = (c_reg != '0);
                nb_idx = pop_idx_reg - IDX_W'(1);
            end
            default:
            begin
                nb_ok  = 1'b0;
                nb_idx = pop_idx_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        lp_next       = lp_reg;
        sea_next      = sea_reg;
        above_next    = above_reg;
        seeded_next   = seeded_reg;
        clr_next      = clr_reg;
        sr_next       = sr_reg;
        sc_next       = sc_reg;
        cur_next      = cur_reg;
        pop_idx_next  = pop_idx_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        dir_next      = dir_reg;
        nb_last_next  = nb_last_reg;
        nidx_next     = nidx_reg;
        seeding_next  = seeding_reg;
        out_pend_next = out_pend_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(CELLS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (out_pend_reg && out_free)
                    out_pend_next = 1'b0;
                if (in_beat)
                begin
                    unique case (op)
                        OP_LOAD:
                        begin
                            if (load_ok)
                                lp_next = lp_reg + CNT_W'(1);
                        end
                        OP_ADVANCE:
                        begin
                            if (sea_reg != LEVEL_MAX)
                                sea_next = sea_reg + YEAR_W'(1);
                            if (!seeded_reg)
                            begin
                                above_next   = area;
                                seeded_next  = 1'b1;
                                sr_next      = '0;
                                sc_next      = '0;
                                cur_next     = '0;
                                nidx_next    = '0;
                                seeding_next = 1'b1;
                                state_next   = ST_MARK_RD;
                            end
                            else
                            begin
                                state_next = ST_CHECK;
                            end
                        end
                        OP_RESTART:
                        begin
                            lp_next     = '0;
                            sea_next    = '0;
                            above_next  = '0;
                            seeded_next = 1'b0;
                            clr_next    = '0;
                            state_next  = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEED_NEXT:
            begin
                state_next = ST_MARK_RD;
                if (!c_last)
                begin
                    if (interior && sc_reg == '0)
                    begin
                        sc_next  = cols - CFG_W'(1);
                        cur_next = cur_reg + IDX_W'(cols - CFG_W'(1));
                    end
                    else
                    begin
                        sc_next  = sc_reg + CFG_W'(1);
                        cur_next = cur_reg + IDX_W'(1);
                    end
                end
                else if (!r_last)
                begin
                    sr_next  = sr_reg + CFG_W'(1);
                    sc_next  = '0;
                    cur_next = cur_reg + IDX_W'(1);
                end
                else
                begin
                    seeding_next = 1'b0;
                    state_next   = ST_CHECK;
                end
                nidx_next = cur_next;
            end
            ST_CHECK:
            begin
                if (!hbusy)
                begin
                    if (sink)
                    begin
                        pop_idx_next = htop[IDX_W-1:0];
                        if (above_reg != '0)
                            above_next = above_reg - CNT_W'(1);
                        state_next = ST_DIV;
                    end
                    else if (out_free)
                    begin
                        out_pend_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    r_next       = div_q;
                    c_next       = div_r;
                    dir_next     = DIR_DOWN;
                    nb_last_next = 1'b0;
                    state_next   = (33'(div_q) >= 33'(rows)) ? ST_CHECK : ST_NB;
                end
            end
            ST_NB:
            begin
                dir_next     = dir_t'(dir_reg + 2'd1);
                nb_last_next = (dir_reg == DIR_LEFT);
                if (nb_ok)
                begin
                    nidx_next  = nb_idx;
                    state_next = ST_MARK_RD;
                end
                else if (dir_reg == DIR_LEFT)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_MARK_RD:
            begin
                state_next = ST_MARK_CHK;
            end
            ST_MARK_CHK:
            begin
                if (!hbusy)
                begin
                    if (seeding_reg)
                        state_next = ST_SEED_NEXT;
                    else if (nb_last_reg)
                        state_next = ST_CHECK;
                    else
                        state_next = ST_NB;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb
    begin
        elev_we   = 1'b0;
        vis_we    = 1'b0;
        vis_wdata = 1'b0;
        vis_waddr = nidx_reg;
        hcmd      = '0;
        hpush_key = {elev_rd_reg, nidx_reg};
        div_start = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
            end
            ST_IDLE:
            begin
                elev_we    = in_beat && (op == OP_LOAD) && load_ok;
                hcmd.clear = in_beat && (op == OP_RESTART);
            end
            ST_CHECK:
            begin
                hcmd.pop  = !hbusy && sink;
                div_start = !hbusy && sink;
            end
            ST_MARK_CHK:
            begin
                vis_we    = !hbusy && !vis_rd_reg;
                vis_wdata = 1'b1;
                hcmd.push = !hbusy && !vis_rd_reg;
            end
            default:
            begin
                hcmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (elev_we)
            elev_mem[IDX_W'(lp_reg)] <= in_elev;
        elev_rd_reg <= elev_mem[nidx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
            vis_mem[vis_waddr] <= vis_wdata;
        vis_rd_reg <= vis_mem[nidx_reg];
    end

    pfsc_heap #(
        .DEPTH (CELLS),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W),
        .KEY_W (KEY_W)
    ) u_heap (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (hcmd),
        .push_key (hpush_key),
        .busy     (hbusy),
        .top_key  (htop),
        .size     (hsize)
    );

    pfsc_div #(
        .N_W (IDX_W),
        .D_W (CFG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (htop[IDX_W-1:0]),
        .divisor  (cols),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_count_reg <= CFG_W'(64);
            col_count_reg <= CFG_W'(64);
            lp_reg        <= '0;
            sea_reg       <= '0;
            above_reg     <= '0;
            seeded_reg    <= 1'b0;
            clr_reg       <= '0;
            seeding_reg   <= 1'b0;
            nb_last_reg   <= 1'b0;
            dir_reg       <= DIR_DOWN;
            out_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lp_reg       <= lp_next;
            sea_reg      <= sea_next;
            above_reg    <= above_next;
            seeded_reg   <= seeded_next;
            clr_reg      <= clr_next;
            seeding_reg  <= seeding_next;
            nb_last_reg  <= nb_last_next;
            dir_reg      <= dir_next;
            out_pend_reg <= out_pend_next;
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_ROWS: row_count_reg <= cfg_data;
                    REG_COLS: col_count_reg <= cfg_data;
                    default:  row_count_reg <= row_count_reg;
                endcase
            end
            if (state_reg == ST_CHECK && state_next == ST_IDLE)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg      <= sr_next;
        sc_reg      <= sc_next;
        cur_reg     <= cur_next;
        pop_idx_reg <= pop_idx_next;
        r_reg       <= r_next;
        c_reg       <= c_next;
        nidx_reg    <= nidx_next;
        if (state_reg == ST_CHECK && state_next == ST_IDLE)
        begin
            out_cnt_reg  <= CNT_FIELD_W'(above_reg);
            out_year_reg <= sea_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - CNT_FIELD_W - YEAR_W)'(0), out_year_reg, out_cnt_reg};

endmodule
`default_nettype wire

/* rtl/pfsc_div.sv */
`default_nettype none
module pfsc_div import pfsc_pkg::*; #(
    parameter int N_W = 12,
    parameter int D_W = 7
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quot,
    output logic [D_W-1:0] rem
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W:0]     trial;
    logic             fits;

    // one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[N_W-1]};
        fits      = trial >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(N_W);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = (quo_reg << 1) | N_W'(fits);
            rem_next = fits ? D_W'(trial - {1'b0, divisor}) : D_W'(trial);
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

/* rtl/pfsc_heap.sv */
`default_nettype none
module pfsc_heap import pfsc_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int IDX_W = 12,
    parameter int CNT_W = 13,
    parameter int KEY_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  heap_cmd_t        cmd,
    input  logic [KEY_W-1:0] push_key,
    output logic             busy,
    output logic [KEY_W-1:0] top_key,
    output logic [CNT_W-1:0] size
);

    localparam int PW = IDX_W + 1;
    localparam int CW = IDX_W + 2;

    logic [KEY_W-1:0] mem [DEPTH];

    heap_state_t      state_reg, state_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] size_reg, size_next;
    logic [KEY_W-1:0] top_reg;
    logic [KEY_W-1:0] rd_a_reg, rd_b_reg;

    logic             we;
    logic [IDX_W-1:0] waddr, ra, rb;
    logic [KEY_W-1:0] wdata;

    logic [PW-1:0]    parent;
    logic [CW-1:0]    lch, rch;
    logic             l_ok, r_ok, a_less, b_less, dn_move, up_stop;
    logic [KEY_W-1:0] child_key;
    logic [PW-1:0]    child_pos;

    always_comb
    begin
        parent    = (pos_reg - PW'(1)) >> 1;
        lch       = (CW'(pos_reg) << 1) + CW'(1);
        rch       = (CW'(pos_reg) << 1) + CW'(2);
        l_ok      = CW'(size_reg) > lch;
        r_ok      = CW'(size_reg) > rch;
        a_less    = rd_a_reg < key_reg;
        b_less    = r_ok && (rd_b_reg < (a_less ? rd_a_reg : key_reg));
        dn_move   = a_less || b_less;
        child_key = b_less ? rd_b_reg : rd_a_reg;
        child_pos = b_less ? PW'(rch) : PW'(lch);
        up_stop   = rd_a_reg <= key_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        size_next  = size_reg;
        unique case (state_reg)
            HS_IDLE:
            begin
                if (cmd.clear)
                begin
                    size_next = '0;
                end
                else if (cmd.push && size_reg != CNT_W'(DEPTH))
                begin
                    pos_next   = PW'(size_reg);
                    key_next   = push_key;
                    size_next  = size_reg + CNT_W'(1);
                    state_next = HS_UP_RD;
                end
                else if (cmd.pop && size_reg != '0)
                begin
                    size_next  = size_reg - CNT_W'(1);
                    state_next = HS_DN_LAST;
                end
            end
            HS_UP_RD:
            begin
                state_next = (pos_reg == '0) ? HS_IDLE : HS_UP_CMP;
            end
            HS_UP_CMP:
            begin
                if (up_stop)
                begin
                    state_next = HS_IDLE;
                end
                else
                begin
                    pos_next   = parent;
                    state_next = HS_UP_RD;
                end
            end
            HS_DN_LAST:
            begin
                state_next = (size_reg == '0) ? HS_IDLE : HS_DN_KEY;
            end
            HS_DN_KEY:
            begin
                key_next   = rd_a_reg;
                pos_next   = '0;
                state_next = HS_DN_RD;
            end
            HS_DN_RD:
            begin
                state_next = l_ok ? HS_DN_CMP : HS_IDLE;
            end
            HS_DN_CMP:
            begin
                if (dn_move)
                begin
                    pos_next   = child_pos;
                    state_next = HS_DN_RD;
                end
                else
                begin
                    state_next = HS_IDLE;
                end
            end
            default:
            begin
                state_next = HS_IDLE;
            end
        endcase
    end

    // memory control
    always_comb
    begin
        we    = 1'b0;
        waddr = IDX_W'(pos_reg);
        wdata = key_reg;
        ra    = '0;
        rb    = IDX_W'(rch);
        unique case (state_reg)
            HS_UP_RD:
            begin
                ra = IDX_W'(parent);
                we = (pos_reg == '0);
            end
            HS_UP_CMP:
            begin
                we    = 1'b1;
                wdata = up_stop ? key_reg : rd_a_reg;
            end
            HS_DN_LAST:
            begin
                ra = IDX_W'(size_reg);
            end
            HS_DN_RD:
            begin
                ra = IDX_W'(lch);
                we = !l_ok;
            end
            HS_DN_CMP:
            begin
                we    = 1'b1;
                wdata = dn_move ? child_key : key_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[ra];
        rd_b_reg <= mem[rb];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= HS_IDLE;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        key_reg <= key_next;
        if (we && waddr == '0)
        begin
            top_reg <= wdata;
        end
    end

    assign busy    = (state_reg != HS_IDLE);
    assign top_key = top_reg;
    assign size    = size_reg;

endmodule
`default_nettype wire

/* rtl/pfsc_check.sv */
`default_nettype none
module pfsc_check import pfsc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [OP_W-1:0]       s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == OP_LOAD |=> s_tready)
        else $error("load beat did not finish in one cycle");

    a_adv_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == OP_ADVANCE |=> !s_tready)
        else $error("ready high right after advance beat");

    a_rst_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == OP_RESTART |=> !s_tready)
        else $error("ready high during mark clearing");

endmodule

bind priority_flood_sinking_count_top pfsc_check u_pfsc_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
